>>> src/cave_automaton_smoothing_pass_macros.svh
// Assertion macros shared by the cave smoothing modules.
`ifndef CAVE_AUTOMATON_SMOOTHING_PASS_MACROS_SVH
`define CAVE_AUTOMATON_SMOOTHING_PASS_MACROS_SVH

// Same-cycle implication, checked on i_clk outside of reset.
`define CAS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside of reset.
`define CAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/cas_pkg.sv
// Shared types and constants of the cave smoothing pass.
package cas_pkg;

    localparam int ROW_W     = 64;
    localparam int ROW_IDX_W = 6;
    localparam int SIZE_W    = 7;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int HIST_ROWS = 6;
    localparam int PATCH     = 7;
    localparam int MIN_SIZE  = 4;

    localparam logic [4:0] LIMIT_5X5 = 5'd18;
    localparam logic [5:0] LIMIT_7X7 = 6'd38;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_SIZE = 2'd0,
        REG_RULE_MODE = 2'd1,
        REG_WALL_THR  = 2'd2,
        REG_OPEN_LIM  = 2'd3
    } t_reg_idx;

    typedef enum logic {
        RULE_SHAPING   = 1'b0,
        RULE_SMOOTHING = 1'b1
    } t_rule_mode;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        t_rule_mode        mode;
        logic [3:0]        wall_thr;
        logic [4:0]        open_lim;
    } t_cfg;

    // Wall counts of one column over the middle 3, 5 and 7 rows of the patch.
    typedef struct packed {
        logic [1:0] v3;
        logic [2:0] v5;
        logic [2:0] v7;
    } t_vsum;

    localparam t_vsum VSUM_FULL = '{v3: 2'd3, v5: 3'd5, v7: 3'd7};

    typedef struct packed {
        logic [ROW_IDX_W-1:0] row;
        logic                 last;
    } t_job;

    typedef struct packed {
        logic [ROW_W-1:0] row_cells;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]     out_cells;
        logic [ROW_IDX_W-1:0] out_row;
        logic                 last_row;
    } t_out_item;

endpackage

>>> src/cas_stream_if.sv
// Valid/ready channel that moves one word per handshake.
interface cas_stream_if #(
    parameter type t_data = logic
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/cas_window.sv
// Row window, grid row counter, end-of-grid flush and per-column vertical wall counts.
`include "cave_automaton_smoothing_pass_macros.svh"

module cas_window #(
    parameter int MAX_SIZE = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cas_stream_if.sink     i_row_ch,
    input  cas_pkg::t_cfg  i_cfg,
    input  logic           i_down_ready,
    output logic           o_valid,
    output cas_pkg::t_job  o_job,
    output cas_pkg::t_vsum o_vsum [MAX_SIZE]
);
    import cas_pkg::*;

    logic [ROW_W-1:0]     r_win [HIST_ROWS];
    logic [ROW_IDX_W-1:0] r_rows;
    logic [1:0]           r_flush;
    logic                 r_v_valid;
    t_job                 r_job;
    t_vsum                r_vsum [MAX_SIZE];

    logic [ROW_IDX_W-1:0] w_k;
    logic                 w_is_last;
    logic                 w_adv;
    logic                 w_accept;
    logic                 w_flushing;
    logic                 w_flush_step;
    logic [ROW_W-1:0]     w_new_row;
    logic [ROW_W-1:0]     w_pad;
    logic [ROW_W-1:0]     w_patch [PATCH];
    logic                 n_v_valid;
    t_job                 n_job;
    t_vsum                n_vsum [MAX_SIZE];

    // A row counter at or past the grid size starts a new grid.
    assign w_k = ({1'b0, r_rows} >= i_cfg.size) ? '0 : r_rows;
    assign w_is_last = ({1'b0, w_k} == (i_cfg.size - SIZE_W'(1)));

    assign w_flushing   = (r_flush != '0);
    assign w_adv        = !r_v_valid || i_down_ready;
    assign i_row_ch.ready = w_adv && !w_flushing;
    assign w_accept     = i_row_ch.valid && i_row_ch.ready;
    assign w_flush_step = w_flushing && w_adv;

    // Rows past the end of the grid are walls.
    assign w_new_row = w_flushing ? '1 : i_row_ch.data.row_cells;
    // Columns at or past the grid size count as walls.
    assign w_pad = {ROW_W{1'b1}} << i_cfg.size;

    always_comb begin
        for (int t = 0; t < HIST_ROWS; t++) begin
            w_patch[t] = r_win[t] | w_pad;
        end
        w_patch[HIST_ROWS] = w_new_row | w_pad;

        for (int c = 0; c < MAX_SIZE; c++) begin
            n_vsum[c].v3 = 2'(w_patch[2][c]) + 2'(w_patch[3][c]) + 2'(w_patch[4][c]);
            n_vsum[c].v5 = 3'(w_patch[1][c]) + 3'(w_patch[2][c]) + 3'(w_patch[3][c])
                         + 3'(w_patch[4][c]) + 3'(w_patch[5][c]);
            n_vsum[c].v7 = n_vsum[c].v5 + 3'(w_patch[0][c]) + 3'(w_patch[6][c]);
        end

        n_v_valid = 1'b0;
        n_job     = r_job;
        if (w_flush_step) begin
            n_v_valid = 1'b1;
            n_job.row = ROW_IDX_W'(i_cfg.size - {5'b0, r_flush});
            n_job.last = (r_flush == 2'd1);
        end else if (w_accept && (w_k >= ROW_IDX_W'(3))) begin
            n_v_valid  = 1'b1;
            n_job.row  = w_k - ROW_IDX_W'(3);
            n_job.last = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= '0;
            r_flush   <= '0;
            r_v_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_rows  <= w_is_last ? '0 : w_k + ROW_IDX_W'(1);
                r_flush <= w_is_last ? 2'd3 : 2'd0;
            end else if (w_flush_step) begin
                r_flush <= r_flush - 2'd1;
            end
            if (w_adv) begin
                r_v_valid <= n_v_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (w_k == '0)) begin
            // Rows above the top of the grid are walls.
            for (int t = 0; t < HIST_ROWS - 1; t++) begin
                r_win[t] <= '1;
            end
            r_win[HIST_ROWS-1] <= w_new_row;
        end else if (w_accept || w_flush_step) begin
            for (int t = 0; t < HIST_ROWS - 1; t++) begin
                r_win[t] <= r_win[t+1];
            end
            r_win[HIST_ROWS-1] <= w_new_row;
        end
        if (w_adv && n_v_valid) begin
            r_job  <= n_job;
            r_vsum <= n_vsum;
        end
    end

    assign o_valid = r_v_valid;
    assign o_job   = r_job;
    assign o_vsum  = r_vsum;

    `CAS_ASSERT_NEXT(a_last_starts_flush, w_accept && w_is_last, r_flush == 2'd3, "last row did not start the flush")
    `CAS_ASSERT_IMP(a_flush_after_wrap, w_flushing, r_rows == '0, "row count not restarted during flush")
    `CAS_ASSERT_IMP(a_job_in_grid, r_v_valid, {1'b0, r_job.row} < i_cfg.size, "job row outside the grid")

endmodule

>>> src/cas_lane.sv
// One column lane: sums the 3x3, 5x5 and 7x7 windows and applies the wall rule.
module cas_lane (
    input  cas_pkg::t_vsum i_vsum [cas_pkg::PATCH],
    input  cas_pkg::t_cfg  i_cfg,
    output logic           o_wall
);
    import cas_pkg::*;

    logic [3:0] w_sum3;
    logic [4:0] w_sum5;
    logic [5:0] w_sum7;
    logic       w_rule3;

    // Tap o holds the column at offset o - 3 from this lane.
    assign w_sum3 = 4'(i_vsum[2].v3) + 4'(i_vsum[3].v3) + 4'(i_vsum[4].v3);
    assign w_sum5 = 5'(i_vsum[1].v5) + 5'(i_vsum[2].v5) + 5'(i_vsum[3].v5)
                  + 5'(i_vsum[4].v5) + 5'(i_vsum[5].v5);
    assign w_sum7 = 6'(i_vsum[0].v7) + 6'(i_vsum[1].v7) + 6'(i_vsum[2].v7)
                  + 6'(i_vsum[3].v7) + 6'(i_vsum[4].v7) + 6'(i_vsum[5].v7)
                  + 6'(i_vsum[6].v7);

    assign w_rule3 = (w_sum3 >= i_cfg.wall_thr);

    always_comb begin
        if (i_cfg.mode == RULE_SHAPING) begin
            o_wall = (w_sum5 > LIMIT_5X5) || (w_sum7 > LIMIT_7X7) || w_rule3
                  || (w_sum5 <= i_cfg.open_lim);
        end else begin
            o_wall = w_rule3;
        end
    end

endmodule

>>> src/cas_merge.sv
// Runs the column lanes and merges their bits into the registered output row.
`include "cave_automaton_smoothing_pass_macros.svh"

module cas_merge #(
    parameter int MAX_SIZE = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cas_pkg::t_job  i_job,
    input  cas_pkg::t_vsum i_vsum [MAX_SIZE],
    input  cas_pkg::t_cfg  i_cfg,
    output logic           o_ready,
    cas_stream_if.source   o_row_ch
);
    import cas_pkg::*;

    logic [MAX_SIZE-1:0]  w_wall;
    logic [ROW_W-1:0]     w_wall_row;
    logic [ROW_W-1:0]     n_cells;
    logic                 w_edge_row;
    logic                 w_en;

    logic                 r_o_valid;
    logic [ROW_W-1:0]     r_o_cells;
    logic [ROW_IDX_W-1:0] r_o_row;
    logic                 r_o_last;

    for (genvar c = 0; c < MAX_SIZE; c++) begin : g_lane
        t_vsum w_taps [PATCH];
        for (genvar o = 0; o < PATCH; o++) begin : g_tap
            if ((c + o - 3 < 0) || (c + o - 3 >= MAX_SIZE)) begin : g_out
                assign w_taps[o] = VSUM_FULL;
            end else begin : g_in
                assign w_taps[o] = i_vsum[c + o - 3];
            end
        end
        cas_lane u_lane (
            .i_vsum (w_taps),
            .i_cfg  (i_cfg),
            .o_wall (w_wall[c])
        );
    end

    assign w_wall_row = ROW_W'(w_wall);
    assign w_edge_row = (i_job.row == '0) || ({1'b0, i_job.row} == (i_cfg.size - SIZE_W'(1)));

    // Border cells are forced to wall; columns past the grid read as zero.
    always_comb begin
        for (int c = 0; c < ROW_W; c++) begin
            n_cells[c] = (SIZE_W'(c) < i_cfg.size)
                       && (w_wall_row[c] || w_edge_row || (c == 0)
                           || (SIZE_W'(c) == (i_cfg.size - SIZE_W'(1))));
        end
    end

    assign w_en    = !r_o_valid || o_row_ch.ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_o_cells <= n_cells;
            r_o_row   <= i_job.row;
            r_o_last  <= i_job.last;
        end
    end

    assign o_row_ch.valid          = r_o_valid;
    assign o_row_ch.data.out_cells = r_o_cells;
    assign o_row_ch.data.out_row   = r_o_row;
    assign o_row_ch.data.last_row  = r_o_last;

    `CAS_ASSERT_IMP(a_last_is_bottom, r_o_valid && r_o_last, {1'b0, r_o_row} == (i_cfg.size - SIZE_W'(1)), "last row flag on a row that is not the bottom")
    `CAS_ASSERT_IMP(a_top_row_wall, r_o_valid && (r_o_row == '0), r_o_cells == ~({ROW_W{1'b1}} << i_cfg.size), "top row is not all wall")

endmodule

>>> src/cave_automaton_smoothing_pass.sv
// A row k >= 3 gives new row k-3 through the count register and then the output register.
// Throughput: one row word per cycle unless a stall or the flush holds the input; rows 0..2
// of a grid produce no output word. After the last row of a grid the input is held while the
// flush sequencer emits the bottom three rows.
// Reset clears the configuration to its defaults and the row counter; the window needs no clear.
module cave_automaton_smoothing_pass #(
    parameter int MAX_SIZE = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cas_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cas_pkg::CFG_W-1:0]     i_cfg_data,
    cas_stream_if.sink                    i_row_ch,
    cas_stream_if.source                  o_row_ch
);
    import cas_pkg::*;

    localparam logic [SIZE_W-1:0] MaxN = SIZE_W'(MAX_SIZE);
    localparam logic [SIZE_W-1:0] MinN = SIZE_W'(MIN_SIZE);

    logic [SIZE_W-1:0] r_grid_size;
    t_rule_mode        r_mode;
    logic [3:0]        r_wall_thr;
    logic [4:0]        r_open_lim;

    t_cfg  w_cfg;
    logic  w_v_valid;
    logic  w_m_ready;
    t_job  w_job;
    t_vsum w_vsum [MAX_SIZE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= SIZE_W'(64);
            r_mode      <= RULE_SHAPING;
            r_wall_thr  <= 4'd5;
            r_open_lim  <= 5'd2;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_GRID_SIZE: r_grid_size <= i_cfg_data;
                REG_RULE_MODE: r_mode      <= t_rule_mode'(i_cfg_data[0]);
                REG_WALL_THR:  r_wall_thr  <= i_cfg_data[3:0];
                REG_OPEN_LIM:  r_open_lim  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_grid_size < MinN) begin
            w_cfg.size = MinN;
        end else if (r_grid_size > MaxN) begin
            w_cfg.size = MaxN;
        end else begin
            w_cfg.size = r_grid_size;
        end
        w_cfg.mode     = r_mode;
        w_cfg.wall_thr = r_wall_thr;
        w_cfg.open_lim = r_open_lim;
    end

    cas_window #(
        .MAX_SIZE (MAX_SIZE)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_row_ch     (i_row_ch),
        .i_cfg        (w_cfg),
        .i_down_ready (w_m_ready),
        .o_valid      (w_v_valid),
        .o_job        (w_job),
        .o_vsum       (w_vsum)
    );

    cas_merge #(
        .MAX_SIZE (MAX_SIZE)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_v_valid),
        .i_job    (w_job),
        .i_vsum   (w_vsum),
        .i_cfg    (w_cfg),
        .o_ready  (w_m_ready),
        .o_row_ch (o_row_ch)
    );

endmodule

>>> dv/tb.sv
// Self-checking testbench of the cave smoothing pass: directed grids, then random grids.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cas_pkg::*;

    localparam int GRID_MAX      = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_ROWS   = 190;
    localparam int PLAN_LEN      = 34;

    localparam logic [63:0] ALL_WALL = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic {
        PLAN_WRITE,
        PLAN_ROW
    } t_plan_kind;

    typedef struct {
        t_plan_kind  kind;
        t_reg_idx    addr;
        logic [6:0]  value;
        logic [63:0] cells;
        bit          pinned;
        logic [63:0] pinned_cells;
    } t_plan_step;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    t_reg_idx             cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    cas_stream_if #(.t_data(t_in_item))  row_in ();
    cas_stream_if #(.t_data(t_out_item)) row_out ();

    cave_automaton_smoothing_pass #(
        .MAX_SIZE(GRID_MAX)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_row_ch   (row_in),
        .o_row_ch   (row_out)
    );

    // Shadow copy of the configuration, starting from the reset values.
    logic [6:0]  size_reg = 7'd64;
    t_rule_mode  mode_reg = RULE_SHAPING;
    logic [3:0]  thr_reg  = 4'd5;
    logic [4:0]  lim_reg  = 5'd2;

    // Shadow copy of the row history and the row counter.
    logic [63:0] hist_rows [6];
    int          rows_seen = 0;

    // Seven-row patch of the row being accepted: patch[t] is input row patch_base + t.
    logic [63:0] patch [7];
    int          patch_base;
    int          cur_n;

    t_out_item   pending_rows [$];
    int          mismatch_count = 0;
    bit          feed_calm = 1'b0;

    t_plan_step directed_plan [PLAN_LEN] = '{
        // Default configuration, first rows of a 64-row grid; new row 0 is all border.
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   ALL_WALL,                1'b0, 64'h0},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   64'h0,                   1'b0, 64'h0},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   64'h0123_4567_89AB_CDEF, 1'b1, ALL_WALL},
        // Size below the minimum acts as 4 and restarts the grid.
        '{PLAN_WRITE, REG_GRID_SIZE, 7'd0,   64'h0,                   1'b0, 64'h0},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   64'h0,                   1'b0, 64'h0},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   ALL_WALL,                1'b0, 64'h0},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   64'hF0F0_F0F0_F0F0_F0F0, 1'b0, 64'h0},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   64'h0,                   1'b0, 64'h0},
        // Smoothing with a zero threshold makes everything wall.
        '{PLAN_WRITE, REG_GRID_SIZE, 7'd5,   64'h0,                   1'b0, 64'h0},
        '{PLAN_WRITE, REG_RULE_MODE, 7'd1,   64'h0,                   1'b0, 64'h0},
        '{PLAN_WRITE, REG_WALL_THR,  7'd0,   64'h0,                   1'b0, 64'h0},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   64'h0,                   1'b1, 64'h1F},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   64'h0,                   1'b1, 64'h1F},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   64'h5555_5555_5555_5555, 1'b1, 64'h1F},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   64'h0,                   1'b1, 64'h1F},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   64'h0,                   1'b1, 64'h1F},
        // Shaping with the largest open-area limit fires on every cell.
        '{PLAN_WRITE, REG_GRID_SIZE, 7'd6,   64'h0,                   1'b0, 64'h0},
        '{PLAN_WRITE, REG_RULE_MODE, 7'd0,   64'h0,                   1'b0, 64'h0},
        '{PLAN_WRITE, REG_WALL_THR,  7'd15,  64'h0,                   1'b0, 64'h0},
        '{PLAN_WRITE, REG_OPEN_LIM,  7'd31,  64'h0,                   1'b0, 64'h0},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   64'h0,                   1'b1, 64'h3F},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   64'h0,                   1'b1, 64'h3F},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   ALL_WALL,                1'b1, 64'h3F},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   64'h0,                   1'b1, 64'h3F},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   64'h0,                   1'b1, 64'h3F},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   64'h0,                   1'b1, 64'h3F},
        // Smoothing with a threshold above nine never fires: border only.
        '{PLAN_WRITE, REG_GRID_SIZE, 7'd5,   64'h0,                   1'b0, 64'h0},
        '{PLAN_WRITE, REG_RULE_MODE, 7'd1,   64'h0,                   1'b0, 64'h0},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   ALL_WALL,                1'b0, 64'h0},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   ALL_WALL,                1'b0, 64'h0},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   ALL_WALL,                1'b0, 64'h0},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   ALL_WALL,                1'b0, 64'h0},
        '{PLAN_ROW,   REG_GRID_SIZE, 7'd0,   ALL_WALL,                1'b0, 64'h0}
    };

    function automatic int grid_edge();
        if (size_reg < MIN_SIZE) return MIN_SIZE;
        if (size_reg > GRID_MAX) return GRID_MAX;
        return int'(size_reg);
    endfunction

    // Cells outside the grid and rows outside the patch count as walls.
    function automatic int wall_at(int i, int j);
        int slot;
        if (i < 0 || j < 0 || i >= cur_n || j >= cur_n) return 1;
        slot = i - patch_base;
        if (slot < 0 || slot > 6) return 1;
        return int'(patch[slot][j]);
    endfunction

    function automatic int walls_around(int r, int c, int rad);
        int cnt;
        cnt = 0;
        for (int dr = -rad; dr <= rad; dr++) begin
            for (int dc = -rad; dc <= rad; dc++) begin
                cnt += wall_at(r + dr, c + dc);
            end
        end
        return cnt;
    endfunction

    function automatic logic [63:0] smooth_row(int r);
        logic [63:0] res;
        bit          wall;
        int          one;
        int          two;
        int          three;
        res = '0;
        for (int c = 0; c < cur_n; c++) begin
            one = walls_around(r, c, 1);
            if (mode_reg == RULE_SHAPING) begin
                two   = walls_around(r, c, 2);
                three = walls_around(r, c, 3);
                wall  = two > int'(LIMIT_5X5) || three > int'(LIMIT_7X7) ||
                        one >= int'(thr_reg) || two <= int'(lim_reg);
            end else begin
                wall = one >= int'(thr_reg);
            end
            if (r == 0 || r == cur_n - 1 || c == 0 || c == cur_n - 1) wall = 1'b1;
            res[c] = wall;
        end
        return res;
    endfunction

    // Advances the shadow state by one accepted row and queues the rows it releases.
    task automatic take_row(input logic [63:0] cells, input bit pinned,
                            input logic [63:0] pinned_cells);
        int        n;
        int        k;
        int        first;
        int        last;
        t_out_item item;
        n = grid_edge();
        if (rows_seen >= n) rows_seen = 0;
        k = rows_seen;
        patch_base = k - 6;
        cur_n = n;
        for (int t = 0; t < 6; t++) patch[t] = hist_rows[t];
        patch[6] = cells;
        if (k == n - 1) begin
            first = k - 3;
            last  = k;
        end else if (k >= 3) begin
            first = k - 3;
            last  = k - 3;
        end else begin
            first = 0;
            last  = -1;
        end
        for (int r = first; r <= last; r++) begin
            item.out_cells = pinned ? pinned_cells : smooth_row(r);
            item.out_row   = 6'(r);
            item.last_row  = (r == n - 1);
            pending_rows = {pending_rows, item};
        end
        for (int t = 0; t < 6; t++) hist_rows[t] = patch[t + 1];
        rows_seen = (k == n - 1) ? 0 : k + 1;
    endtask

    function automatic int pause_len(bit calm);
        if (calm) return 0;
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [63:0] cave_row();
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0, 1: return a & b;
            2, 3: return a | b;
            4:    return a & b & c;
            5:    return a | b | c;
            6:    return $urandom_range(0, 1) ? ALL_WALL : 64'h0;
            default: return a;
        endcase
    endfunction

    // Called and returning at a falling edge.
    task automatic write_reg(input t_reg_idx addr, input logic [6:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= addr;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (addr)
            REG_GRID_SIZE: size_reg = value;
            REG_RULE_MODE: mode_reg = t_rule_mode'(value[0]);
            REG_WALL_THR:  thr_reg  = value[3:0];
            REG_OPEN_LIM:  lim_reg  = value[4:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Rows 0..2 give no word, so a settle wait after the queue empties covers work still in flight.
    task automatic drain();
        while (pending_rows.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Called and returning at a falling edge.
    task automatic send_row(input logic [63:0] cells, input bit pinned,
                            input logic [63:0] pinned_cells);
        int gap;
        gap = pause_len(feed_calm);
        if (gap > 0) begin
            row_in.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        row_in.valid          <= 1'b1;
        row_in.data.row_cells <= cells;
        @(posedge i_clk);
        while (!row_in.ready) @(posedge i_clk);
        take_row(cells, pinned, pinned_cells);
        @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #6_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: ready may drop for a random stretch before each word.
    initial begin
        int stall;
        int calm_left;
        bit calm;
        calm_left = 0;
        calm = 1'b0;
        row_out.ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(5, 30);
            end
            calm_left--;
            stall = pause_len(calm);
            if (stall > 0) begin
                row_out.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            row_out.ready <= 1'b1;
            @(posedge i_clk);
            while (!row_out.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && row_out.valid && row_out.ready) begin
            got = row_out.data;
            if (pending_rows.size() == 0) begin
                $error("unexpected output word for row %0d", got.out_row);
                mismatch_count++;
            end else begin
                want = pending_rows.pop_front();
                if (got.out_cells !== want.out_cells) begin
                    $error("out_cells: expected %h, actual %h", want.out_cells, got.out_cells);
                    mismatch_count++;
                end
                if (got.out_row !== want.out_row) begin
                    $error("out_row: expected %0d, actual %0d", want.out_row, got.out_row);
                    mismatch_count++;
                end
                if (got.last_row !== want.last_row) begin
                    $error("last_row: expected %0b, actual %0b", want.last_row, got.last_row);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int          rows_driven;
        int          big_left;
        int          n;
        int          rows_planned;
        logic [6:0]  value;
        rows_driven = 0;
        big_left    = 2;
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = REG_GRID_SIZE;
        cfg_data              = '0;
        row_in.valid          = 1'b0;
        row_in.data.row_cells = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int s = 0; s < PLAN_LEN; s++) begin
            if (directed_plan[s].kind == PLAN_WRITE) begin
                row_in.valid <= 1'b0;
                drain();
                write_reg(directed_plan[s].addr, directed_plan[s].value);
            end else begin
                send_row(directed_plan[s].cells, directed_plan[s].pinned,
                         directed_plan[s].pinned_cells);
            end
        end

        while (rows_driven < RANDOM_ROWS) begin
            row_in.valid <= 1'b0;
            drain();
            if ($urandom_range(0, 3) != 0) begin
                if (big_left > 0 && $urandom_range(0, 11) == 0) begin
                    value = (big_left == 2) ? 7'd127 : 7'd64;
                    big_left--;
                end else begin
                    case ($urandom_range(0, 9))
                        0:       value = 7'($urandom_range(0, 3));
                        1:       value = 7'($urandom_range(13, 40));
                        default: value = 7'($urandom_range(4, 12));
                    endcase
                end
                write_reg(REG_GRID_SIZE, value);
            end
            // Upper data bits are noise; the register keeps only its own width.
            if ($urandom_range(0, 1) == 1) begin
                value    = 7'($urandom);
                write_reg(REG_RULE_MODE, value);
            end
            if ($urandom_range(0, 1) == 1) begin
                value = 7'($urandom);
                case ($urandom_range(0, 7))
                    0:       value[3:0] = 4'($urandom_range(10, 15));
                    1:       value[3:0] = 4'd0;
                    default: value[3:0] = 4'($urandom_range(2, 7));
                endcase
                write_reg(REG_WALL_THR, value);
            end
            if ($urandom_range(0, 1) == 1) begin
                value = 7'($urandom);
                if ($urandom_range(0, 7) == 0) value[4:0] = 5'($urandom_range(25, 31));
                else value[4:0] = 5'($urandom_range(0, 8));
                write_reg(REG_OPEN_LIM, value);
            end
            n = grid_edge();
            // Now and then a grid is cut short, so the next one picks up its count.
            rows_planned = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n - 1) : n;
            feed_calm = ($urandom_range(0, 2) == 0);
            for (int i = 0; i < rows_planned; i++) begin
                send_row(cave_row(), 1'b0, 64'h0);
                rows_driven++;
                if ($urandom_range(0, 23) == 0) begin
                    row_in.valid <= 1'b0;
                    drain();
                end
            end
        end

        row_in.valid <= 1'b0;
        while (pending_rows.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

>>> cave_automaton_smoothing_pass.f
+incdir+src
src/cas_pkg.sv
src/cas_stream_if.sv
src/cas_window.sv
src/cas_lane.sv
src/cas_merge.sv
src/cave_automaton_smoothing_pass.sv
dv/tb.sv
